>>> rtl/kbsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsq_pkg
// Shared types and command codes for the keyboard scan queue.
// ----------------------------------------------------------------------------
package kbsq_pkg;

	localparam int CMD_W  = 3;
	localparam int KEY_W  = 16;
	localparam int CHAR_W = 8;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [KEY_W-1:0]  key_word_t;
	typedef logic [CHAR_W-1:0] char_t;

	// command codes
	localparam cmd_t CMD_PUSH      = 3'd0;
	localparam cmd_t CMD_TEST      = 3'd1;
	localparam cmd_t CMD_PEEK      = 3'd2;
	localparam cmd_t CMD_READ_CHAR = 3'd3;
	localparam cmd_t CMD_READ_WORD = 3'd4;

	// value returned by a test that finds a key waiting
	localparam key_word_t TEST_HIT_WORD = 16'h00ff;

	// one result item
	typedef struct packed {
		key_word_t read_data;
		logic      read_valid;
		logic      key_waiting;
		logic      push_dropped;
	} rsp_t;

endpackage

>>> rtl/kbsq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsq_req_if
// Command channel: valid/ready with command code and key word.
// ----------------------------------------------------------------------------
interface kbsq_req_if;
	import kbsq_pkg::*;

	logic      valid;
	logic      ready;
	cmd_t      cmd;
	key_word_t key_word;

	modport source (output valid, output cmd, output key_word, input ready);
	modport sink (input valid, input cmd, input key_word, output ready);

endinterface

>>> rtl/kbsq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsq_rsp_if
// Result channel: valid/ready with returned data and status flags.
// ----------------------------------------------------------------------------
interface kbsq_rsp_if;
	import kbsq_pkg::*;

	logic      valid;
	logic      ready;
	key_word_t read_data;
	logic      read_valid;
	logic      key_waiting;
	logic      push_dropped;

	modport source (output valid, output read_data, output read_valid,
		output key_waiting, output push_dropped, input ready);
	modport sink (input valid, input read_data, input read_valid,
		input key_waiting, input push_dropped, output ready);

endinterface

>>> rtl/kbsq_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsq_key_ram
// Simple dual-port key store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kbsq_key_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/keyboard_scan_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scan_queue
// Keyboard key buffer: a ring of key words with push, test, peek and reads.
// ----------------------------------------------------------------------------
// Key words (scan code in 15:8, character in 7:0) are held in a ring in a
// synchronous RAM of QUEUE_SLOTS entries; one slot stays free, so at most
// QUEUE_SLOTS-1 keys wait and a push into a full ring is dropped and flagged.
// One command is handled at a time. Push, test, unused codes, an empty peek
// or read, and a character read that returns a held scan code are answered
// from the request; a peek, word read or character read that reaches a stored
// word waits in the READ state for the registered read of the key RAM. A
// character read that pops a zero character returns 0 and holds the scan code
// for the next character read. The RAM needs no clearing after reset: the ring
// only reads slots it has written. The result sits in an output register, so
// a new command is taken in the cycle the previous result is transferred.
module keyboard_scan_queue #(
	parameter int QUEUE_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	kbsq_req_if.sink    request,
	kbsq_rsp_if.source  response
);
	import kbsq_pkg::*;

	localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_SLOTS - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
		next_slot = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
	endfunction

	logic             state_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] wr_idx_q;
	char_t            held_q;
	cmd_t             cmd_s1;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             accept;
	logic             ring_empty;
	logic             ring_full;
	logic             needs_ram;
	logic             push_ok;
	logic [IDX_W-1:0] rd_next;
	key_word_t        ram_word;
	rsp_t             idle_rsp;
	rsp_t             read_rsp;

	// handshake and ring status
	assign request.ready = (state_q == ST_IDLE) && (!out_valid_q || response.ready);
	assign accept        = request.valid && request.ready;
	assign ring_empty    = (rd_idx_q == wr_idx_q);
	assign ring_full     = (next_slot(wr_idx_q) == rd_idx_q);
	assign rd_next       = next_slot(rd_idx_q);
	assign push_ok       = accept && (request.cmd == CMD_PUSH) && !ring_full;

	// commands that need the oldest stored word
	always_comb begin
		case (request.cmd)
			CMD_PEEK:      needs_ram = !ring_empty;
			CMD_READ_WORD: needs_ram = !ring_empty;
			CMD_READ_CHAR: needs_ram = !ring_empty && (held_q == '0);
			default:       needs_ram = 1'b0;
		endcase
	end

	kbsq_key_ram #(
		.DEPTH  (QUEUE_SLOTS),
		.ADDR_W (IDX_W),
		.DATA_W (KEY_W)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (push_ok),
		.wr_addr (wr_idx_q),
		.wr_data (request.key_word),
		.rd_en   (accept && needs_ram),
		.rd_addr (rd_idx_q),
		.rd_data (ram_word)
	);

	// results that need no RAM read
	always_comb begin
		idle_rsp             = '0;
		idle_rsp.key_waiting = !ring_empty;
		case (request.cmd)
			CMD_PUSH: begin
				idle_rsp.push_dropped = ring_full;
				idle_rsp.key_waiting  = 1'b1;
			end
			CMD_TEST: begin
				idle_rsp.read_data = ring_empty ? '0 : TEST_HIT_WORD;
			end
			CMD_READ_CHAR: begin
				if (held_q != '0) begin
					idle_rsp.read_data  = KEY_W'(held_q);
					idle_rsp.read_valid = 1'b1;
				end
			end
			default: begin
				idle_rsp.read_valid = 1'b0;
			end
		endcase
	end

	// results built from the word read out of the ring
	always_comb begin
		read_rsp             = '0;
		read_rsp.read_valid  = 1'b1;
		read_rsp.key_waiting = (rd_next != wr_idx_q);
		case (cmd_s1)
			CMD_PEEK: begin
				read_rsp.read_data   = ram_word;
				read_rsp.key_waiting = 1'b1;
			end
			CMD_READ_CHAR: begin
				read_rsp.read_data = KEY_W'(ram_word[CHAR_W-1:0]);
			end
			default: begin
				read_rsp.read_data = ram_word;
			end
		endcase
	end

	// sequencer, ring pointers and held scan code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			held_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push_ok) begin
						wr_idx_q <= next_slot(wr_idx_q);
					end
					if (accept && (request.cmd == CMD_READ_CHAR) && (held_q != '0)) begin
						held_q <= '0;
					end
					if (accept && needs_ram) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (cmd_s1 != CMD_PEEK) begin
						rd_idx_q <= rd_next;
					end
					if ((cmd_s1 == CMD_READ_CHAR) && (ram_word[CHAR_W-1:0] == '0)) begin
						held_q <= ram_word[KEY_W-1:CHAR_W];
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command held for the read cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= request.cmd;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !needs_ram) || (state_q == ST_READ)) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_q <= read_rsp;
		end else if (accept && !needs_ram) begin
			out_q <= idle_rsp;
		end
	end

	assign response.valid        = out_valid_q;
	assign response.read_data    = out_q.read_data;
	assign response.read_valid   = out_q.read_valid;
	assign response.key_waiting  = out_q.key_waiting;
	assign response.push_dropped = out_q.push_dropped;

endmodule
